// ----- hw/rtl/bla_pkg.sv -----
package bla_pkg;

  // ring geometry
  localparam int unsigned WINDOW = 100;
  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam int unsigned HELD_W = $clog2(WINDOW + 1);

  // data widths
  localparam int unsigned MV_W  = 16;
  localparam int unsigned SUM_W = MV_W + HELD_W;
  localparam int unsigned PCT_W = 7;
  localparam int unsigned NUM_W = MV_W + PCT_W;

  // shared divider
  localparam int unsigned DIV_W      = MV_W;
  localparam int unsigned DIV_STEP_W = $clog2(DIV_W + 1);

  // percent scale and level thresholds
  localparam logic [PCT_W-1:0] PCT_SCALE    = PCT_W'(100);
  localparam logic [PCT_W-1:0] PCT_LOW_MAX  = PCT_W'(20);
  localparam logic [PCT_W-1:0] PCT_HIGH_MIN = PCT_W'(50);

  // register reset values
  localparam logic [MV_W-1:0] EMPTY_MV_RST = MV_W'(3300);
  localparam logic [MV_W-1:0] FULL_MV_RST  = MV_W'(4200);

  // register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_MV = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_MV  = 1'b1;

  typedef enum logic [1:0] {
    LEVEL_LOW  = 2'd0,
    LEVEL_MID  = 2'd1,
    LEVEL_HIGH = 2'd2
  } level_e;

  typedef struct packed {
    logic                  start;
    logic [DIV_STEP_W-1:0] steps;
    logic [DIV_W-1:0]      rem_init;
    logic [DIV_W-1:0]      dividend;
    logic [DIV_W-1:0]      divisor;
  } bla_div_req_t;

endpackage

// ----- hw/rtl/bla_div.sv -----
module bla_div import bla_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bla_div_req_t       req_i,
  output logic               done_o,
  output logic [DIV_W-1:0]   quotient_o
);

  // Restoring division, one quotient bit a cycle. The caller preloads the
  // partial remainder (must be below the divisor) and the low dividend bits.
  logic [DIV_STEP_W-1:0] cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic [DIV_W-1:0]      rem_q, rem_d;
  logic [DIV_W-1:0]      shift_q, shift_d;
  logic [DIV_W-1:0]      quo_q, quo_d;
  logic [DIV_W-1:0]      divisor_q, divisor_d;
  logic [DIV_W:0]        trial;
  logic                  fits;

  assign trial = {rem_q, shift_q[DIV_W-1]};
  assign fits  = trial >= {1'b0, divisor_q};

  always_comb begin
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    rem_d     = rem_q;
    shift_d   = shift_q;
    quo_d     = quo_q;
    divisor_d = divisor_q;
    if (req_i.start) begin
      cnt_d     = req_i.steps;
      rem_d     = req_i.rem_init;
      shift_d   = req_i.dividend;
      quo_d     = '0;
      divisor_d = req_i.divisor;
    end else if (cnt_q != '0) begin
      cnt_d   = cnt_q - DIV_STEP_W'(1);
      done_d  = (cnt_q == DIV_STEP_W'(1));
      rem_d   = fits ? DIV_W'(trial - {1'b0, divisor_q}) : trial[DIV_W-1:0];
      shift_d = {shift_q[DIV_W-2:0], 1'b0};
      quo_d   = {quo_q[DIV_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    shift_q   <= shift_d;
    quo_q     <= quo_d;
    divisor_q <= divisor_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- hw/rtl/battery_level_averager_unit.sv -----
// Channel   Dir  Beat fields                          Handshake
// in        in   sample_mv_i[15:0]                    in_valid_i / in_ready_o
// out       out  average_mv_o, percent_o, level_o     out_valid_o / out_ready_i
// cfg       in   cfg_index_i, cfg_data_i[15:0]        cfg_we_i (no back-pressure)
//
// One beat in flight: a new sample is taken only after the last result has
// reached the result register; full <= empty skips the percent division. The
// shared bit-serial divider runs 16 steps for the mean, 7 for the percent.
// Reset clears window sum, fill count and write pointer; unwritten ring slots
// read as zero through the fill count, so the ring itself is never cleared.
// A stalled result lets one more sample in; it waits in S_OUT, in_ready_o low.
module battery_level_averager_unit import bla_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // sample channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [MV_W-1:0]      sample_mv_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [MV_W-1:0]      average_mv_o,
  output logic [PCT_W-1:0]     percent_o,
  output logic [1:0]           level_o,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [MV_W-1:0]      cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_AVG,
    S_PREP,
    S_PCT,
    S_OUT
  } state_e;

  state_e              state_q, state_d;

  // configuration registers
  logic [MV_W-1:0]     empty_q, empty_d;
  logic [MV_W-1:0]     full_q, full_d;

  // window bookkeeping
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [HELD_W-1:0]   held_q, held_d;
  logic [SUM_W-1:0]    sum_q, sum_d;

  // working registers
  logic [MV_W-1:0]     sample_q, sample_d;
  logic [MV_W-1:0]     avg_q, avg_d;
  logic [PCT_W-1:0]    pct_q, pct_d;

  // result register
  logic                out_valid_q, out_valid_d;
  logic [MV_W-1:0]     out_avg_q, out_avg_d;
  logic [PCT_W-1:0]    out_pct_q, out_pct_d;
  level_e              out_lvl_q, out_lvl_d;

  // ring memory, read on accept, written in the update cycle
  logic [MV_W-1:0]     ring_q [WINDOW];
  logic [MV_W-1:0]     rd_q;
  logic                in_fire;
  logic                ring_we;

  // datapath helpers
  logic [MV_W-1:0]     oldest;
  logic                range_ok;
  logic [MV_W-1:0]     clamped;
  logic [MV_W-1:0]     span;
  logic [NUM_W-1:0]    numer;
  level_e              lvl;

  bla_div_req_t        div_req;
  logic                div_done;
  logic [DIV_W-1:0]    div_quo;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign ring_we    = (state_q == S_SUM);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_q <= ring_q[slot_q];
    end
    if (ring_we) begin
      ring_q[slot_q] <= sample_q;
    end
  end

  // Slots at or beyond the fill count were never written and count as zero.
  // While filling, the write pointer always equals the fill count.
  assign oldest = (held_q == HELD_W'(WINDOW)) ? rd_q : '0;

  // Percent path: clamp high then low, scale by 100.
  assign range_ok = full_q > empty_q;
  always_comb begin
    clamped = avg_q;
    if (clamped > full_q) begin
      clamped = full_q;
    end
    if (clamped < empty_q) begin
      clamped = empty_q;
    end
  end
  assign span  = full_q - empty_q;
  assign numer = NUM_W'(clamped - empty_q) * NUM_W'(PCT_SCALE);

  always_comb begin
    if (pct_q <= PCT_LOW_MAX) begin
      lvl = LEVEL_LOW;
    end else if (pct_q > PCT_HIGH_MIN) begin
      lvl = LEVEL_HIGH;
    end else begin
      lvl = LEVEL_MID;
    end
  end

  always_comb begin
    state_d     = state_q;
    empty_d     = empty_q;
    full_d      = full_q;
    slot_d      = slot_q;
    held_d      = held_q;
    sum_d       = sum_q;
    sample_d    = sample_q;
    avg_d       = avg_q;
    pct_d       = pct_q;
    out_valid_d = out_valid_q;
    out_avg_d   = out_avg_q;
    out_pct_d   = out_pct_q;
    out_lvl_d   = out_lvl_q;
    div_req     = '0;

    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_EMPTY_MV: empty_d = cfg_data_i;
        CFG_FULL_MV:  full_d  = cfg_data_i;
        default: ;
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          sample_d = sample_mv_i;
          state_d  = S_SUM;
        end
      end
      S_SUM: begin
        sum_d  = sum_q - SUM_W'(oldest) + SUM_W'(sample_q);
        held_d = (held_q == HELD_W'(WINDOW)) ? held_q : held_q + HELD_W'(1);
        slot_d = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
        // mean fits 16 bits, so the top sum bits already sit below the count
        div_req.start    = 1'b1;
        div_req.steps    = DIV_STEP_W'(DIV_W);
        div_req.rem_init = DIV_W'(sum_d[SUM_W-1:DIV_W]);
        div_req.dividend = sum_d[DIV_W-1:0];
        div_req.divisor  = DIV_W'(held_d);
        state_d          = S_AVG;
      end
      S_AVG: begin
        if (div_done) begin
          avg_d   = div_quo;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        if (range_ok) begin
          // quotient is at most 100, so only the last 7 bits need steps
          div_req.start    = 1'b1;
          div_req.steps    = DIV_STEP_W'(PCT_W);
          div_req.rem_init = numer[NUM_W-1:PCT_W];
          div_req.dividend = {numer[PCT_W-1:0], (DIV_W-PCT_W)'(0)};
          div_req.divisor  = span;
          state_d          = S_PCT;
        end else begin
          pct_d   = '0;
          state_d = S_OUT;
        end
      end
      S_PCT: begin
        if (div_done) begin
          pct_d   = div_quo[PCT_W-1:0];
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_avg_d   = avg_q;
          out_pct_d   = pct_q;
          out_lvl_d   = lvl;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      empty_q     <= EMPTY_MV_RST;
      full_q      <= FULL_MV_RST;
      slot_q      <= '0;
      held_q      <= '0;
      sum_q       <= '0;
      sample_q    <= '0;
      avg_q       <= '0;
      pct_q       <= '0;
      out_valid_q <= 1'b0;
      out_avg_q   <= '0;
      out_pct_q   <= '0;
      out_lvl_q   <= LEVEL_LOW;
    end else begin
      state_q     <= state_d;
      empty_q     <= empty_d;
      full_q      <= full_d;
      slot_q      <= slot_d;
      held_q      <= held_d;
      sum_q       <= sum_d;
      sample_q    <= sample_d;
      avg_q       <= avg_d;
      pct_q       <= pct_d;
      out_valid_q <= out_valid_d;
      out_avg_q   <= out_avg_d;
      out_pct_q   <= out_pct_d;
      out_lvl_q   <= out_lvl_d;
    end
  end

  bla_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_valid_o  = out_valid_q;
  assign average_mv_o = out_avg_q;
  assign percent_o    = out_pct_q;
  assign level_o      = out_lvl_q;

endmodule

// ----- hw/rtl/bla_chk.sv -----
module bla_chk import bla_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic [MV_W-1:0]      sample_mv_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [MV_W-1:0]      average_mv_o,
  input logic [PCT_W-1:0]     percent_o,
  input logic [1:0]           level_o,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_index_i,
  input logic [MV_W-1:0]      cfg_data_i
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(average_mv_o)
      && $stable(percent_o) && $stable(level_o))
    else $error("result beat changed while stalled");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> percent_o <= PCT_SCALE)
    else $error("percent above full scale");

  a_level_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((percent_o <= PCT_LOW_MAX) == (level_o == LEVEL_LOW)))
    else $error("low level disagrees with percent");

  a_level_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((percent_o > PCT_HIGH_MIN) == (level_o == LEVEL_HIGH)))
    else $error("high level disagrees with percent");

  // one sample in flight at a time
  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second sample taken while one is in flight");

endmodule

bind battery_level_averager_unit bla_chk u_bla_chk (.*);
